### rtl/ims_pkg.sv
// ims_pkg: shared sizes, state type and memory control bundle of the merge sorter
// no dependencies; imported by the sequencer and the top level
package ims_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int CNT_W       = IDX_W + 1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RUN,
        S_MERGE,
        S_OUT_RD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                   we_a;
        logic                   we_b;
        logic [IDX_W-1:0]       waddr;
        logic [VALUE_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]       raddr0;
        logic [IDX_W-1:0]       raddr1;
        logic                   sel_b;
    } t_mem_ctrl;

endpackage

### rtl/ims_if.sv
// ims_if: valid/ready channel interfaces for input and result transactions
// depends on ims_pkg for the value width
interface ims_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ims_pkg::VALUE_WIDTH-1:0] sample_value;
    logic                                 end_of_set;

    modport source (output valid, output sample_value, output end_of_set, input ready);
    modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

interface ims_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ims_pkg::VALUE_WIDTH-1:0] sorted_value;
    logic                                 final_item;
    logic                                 capacity_exceeded;

    modport source (output valid, output sorted_value, output final_item,
                    output capacity_exceeded, input ready);
    modport sink   (input valid, input sorted_value, input final_item,
                    input capacity_exceeded, output ready);
endinterface

### rtl/ims_ram.sv
// ims_ram: generic memory, one write port and two registered read ports
// no dependencies
module ims_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr0,
    input  logic [ADDR_W-1:0] i_raddr1,
    output logic [WIDTH-1:0]  o_rdata0,
    output logic [WIDTH-1:0]  o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

### rtl/ims_seq.sv
// ims_seq: load, bottom-up merge and output sequencer with the shared compare unit
// depends on ims_pkg; drives the two memory banks through a t_mem_ctrl bundle
module ims_seq (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic [ims_pkg::VALUE_WIDTH-1:0]      i_sample_value,
    input  logic                                 i_end_of_set,
    output logic                                 o_in_ready,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic                                 o_final_item,
    output logic                                 o_capacity_exceeded,
    input  logic [ims_pkg::VALUE_WIDTH-1:0]      i_rd_i,
    input  logic [ims_pkg::VALUE_WIDTH-1:0]      i_rd_j,
    output ims_pkg::t_mem_ctrl                   o_mem
);
    import ims_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_w, n_w;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_mid, n_mid;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_k, n_k;
    logic             r_src_b, n_src_b;

    logic             in_acc;
    logic             has_room;
    logic [CNT_W-1:0] load_count;
    logic [CNT_W:0]   sum_mid;
    logic [CNT_W:0]   sum_hi;
    logic [CNT_W-1:0] run_mid;
    logic [CNT_W-1:0] run_hi;
    logic             take_j;
    logic             run_done;
    logic [CNT_W:0]   lo_next;
    logic [CNT_W:0]   w_next;
    logic             last_out;

    assign in_acc     = i_in_valid && o_in_ready;
    assign has_room   = r_count < CNT_W'(MAX_ITEMS);
    assign load_count = has_room ? r_count + 1'b1 : r_count;

    assign sum_mid = {1'b0, r_lo} + {1'b0, r_w};
    assign sum_hi  = {1'b0, r_lo} + {r_w, 1'b0};
    assign run_mid = (sum_mid >= {1'b0, r_n}) ? r_n : sum_mid[CNT_W-1:0];
    assign run_hi  = (sum_hi  >= {1'b0, r_n}) ? r_n : sum_hi[CNT_W-1:0];

    // shared compare unit
    assign take_j   = (r_j < r_hi) &&
                      ((r_i >= r_mid) || ($signed(i_rd_j) < $signed(i_rd_i)));
    assign run_done = (r_k + 1'b1) == r_hi;
    assign lo_next  = {1'b0, r_lo} + {r_w, 1'b0};
    assign w_next   = {r_w, 1'b0};
    assign last_out = (r_k + 1'b1) == r_n;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && i_end_of_set) begin
                    n_state = (load_count > CNT_W'(1)) ? S_RUN : S_OUT_RD;
                end
            end
            S_RUN: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (run_done) begin
                    if (lo_next >= {1'b0, r_n} && w_next >= {1'b0, r_n}) begin
                        n_state = S_OUT_RD;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = last_out ? S_LOAD : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_n     = r_n;
        n_w     = r_w;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_src_b = r_src_b;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    n_count = load_count;
                    if (!has_room) begin
                        n_ovf = 1'b1;
                    end
                    if (i_end_of_set) begin
                        n_n     = load_count;
                        n_w     = CNT_W'(1);
                        n_lo    = '0;
                        n_k     = '0;
                        n_src_b = 1'b0;
                    end
                end
            end
            S_RUN: begin
                n_mid = run_mid;
                n_hi  = run_hi;
                n_i   = r_lo;
                n_j   = run_mid;
                n_k   = r_lo;
            end
            S_MERGE: begin
                n_k = r_k + 1'b1;
                if (take_j) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
                if (run_done) begin
                    if (lo_next >= {1'b0, r_n}) begin
                        n_src_b = ~r_src_b;
                        n_lo    = '0;
                        n_w     = w_next[CNT_W-1:0];
                        n_k     = '0;
                    end else begin
                        n_lo = lo_next[CNT_W-1:0];
                    end
                end
            end
            S_OUT_RD: begin
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (last_out) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_k     = '0;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // outputs and memory control
    always_comb begin
        o_in_ready          = 1'b0;
        o_out_valid         = 1'b0;
        o_final_item        = last_out;
        o_capacity_exceeded = r_ovf;
        o_mem.we_a          = 1'b0;
        o_mem.we_b          = 1'b0;
        o_mem.waddr         = r_count[IDX_W-1:0];
        o_mem.wdata         = i_sample_value;
        o_mem.raddr0        = n_i[IDX_W-1:0];
        o_mem.raddr1        = n_j[IDX_W-1:0];
        o_mem.sel_b         = r_src_b;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_mem.we_a = i_in_valid && has_room;
            end
            S_RUN: begin
            end
            S_MERGE: begin
                o_mem.waddr = r_k[IDX_W-1:0];
                o_mem.wdata = take_j ? i_rd_j : i_rd_i;
                o_mem.we_a  = r_src_b;
                o_mem.we_b  = ~r_src_b;
            end
            S_OUT_RD: begin
                o_mem.raddr0 = r_k[IDX_W-1:0];
            end
            S_OUT: begin
                o_out_valid  = 1'b1;
                o_mem.raddr0 = r_k[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_src_b <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_src_b <= n_src_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_w   <= n_w;
        r_lo  <= n_lo;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
    end

endmodule

### rtl/integer_merge_sorter_core.sv
// integer_merge_sorter_core: load one value per cycle while ready in the load state, merge sort, then emit in order
// sort of n values (n up to 64) takes ceil(log2 n) passes over the values, one merge step per cycle
// output: each result is read from the sorted bank through the registered read (S_OUT_RD, then S_OUT)
// reset: synchronous active low, clears count, overflow flag and sequencer; memories are not cleared
module integer_merge_sorter_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ims_in_if.sink    i_in,
    ims_out_if.source o_out
);
    import ims_pkg::*;

    t_mem_ctrl              mem;
    logic [VALUE_WIDTH-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
    logic [VALUE_WIDTH-1:0] rd_i, rd_j;

    ims_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (VALUE_WIDTH)
    ) u_bank_a (
        .i_clk    (i_clk),
        .i_we     (mem.we_a),
        .i_waddr  (mem.waddr),
        .i_wdata  (mem.wdata),
        .i_raddr0 (mem.raddr0),
        .i_raddr1 (mem.raddr1),
        .o_rdata0 (a_rd0),
        .o_rdata1 (a_rd1)
    );

    ims_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (VALUE_WIDTH)
    ) u_bank_b (
        .i_clk    (i_clk),
        .i_we     (mem.we_b),
        .i_waddr  (mem.waddr),
        .i_wdata  (mem.wdata),
        .i_raddr0 (mem.raddr0),
        .i_raddr1 (mem.raddr1),
        .o_rdata0 (b_rd0),
        .o_rdata1 (b_rd1)
    );

    // source bank select
    assign rd_i = mem.sel_b ? b_rd0 : a_rd0;
    assign rd_j = mem.sel_b ? b_rd1 : a_rd1;

    ims_seq u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in.valid),
        .i_sample_value      (i_in.sample_value),
        .i_end_of_set        (i_in.end_of_set),
        .o_in_ready          (i_in.ready),
        .i_out_ready         (o_out.ready),
        .o_out_valid         (o_out.valid),
        .o_final_item        (o_out.final_item),
        .o_capacity_exceeded (o_out.capacity_exceeded),
        .i_rd_i              (rd_i),
        .i_rd_j              (rd_j),
        .o_mem               (mem)
    );

    assign o_out.sorted_value = rd_i;

endmodule

### test/tb_top.sv
// tb_top: self-checking testbench for integer_merge_sorter_core, sets of signed values
// sorted by a local predictor and compared result by result under random idling
// depends on ims_pkg, ims_if and the integer_merge_sorter_core rtl
module tb_top;
    import ims_pkg::*;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef t_value t_value_list[$];

    typedef struct {
        t_value value;
        logic   last;
        logic   overflow;
    } t_sorted_entry;

    typedef enum {
        VALUES_WIDE,
        VALUES_NARROW,
        VALUES_EDGE
    } t_value_mix;

    localparam t_value VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam t_value VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam int     MAX_IDLE  = 8;
    localparam int     RANDOM_ITEMS = 100;
    localparam int     DRAIN_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;

    ims_in_if  in_if ();
    ims_out_if out_if ();

    integer_merge_sorter_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predictor state: values held for the current set
    t_value        held_values[MAX_ITEMS];
    int            held_count;
    bit            held_overflow;
    t_sorted_entry sorted_expect[$];

    int error_count;
    int sets_sent;
    int items_sent;
    int results_checked;
    int overflow_sets;
    bit in_idle_en;
    bit out_idle_en;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", sorted_expect.size());
        $display("integer_merge_sorter_core test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic absorb_sample(input t_value v, input logic eos);
        t_value        ordered[$];
        t_sorted_entry entry;
        int            i;
        int            pos;
        if (held_count < MAX_ITEMS) begin
            held_values[held_count] = v;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (eos) begin
            // stable insertion sort, signed order
            for (i = 0; i < held_count; i++) begin
                pos = ordered.size();
                while (pos > 0 && ordered[pos-1] > held_values[i])
                    pos--;
                ordered.insert(pos, held_values[i]);
            end
            for (i = 0; i < held_count; i++) begin
                entry.value    = ordered[i];
                entry.last     = (i == held_count - 1);
                entry.overflow = held_overflow;
                sorted_expect.push_back(entry);
            end
            if (held_overflow)
                overflow_sets++;
            sets_sent++;
            held_count    = 0;
            held_overflow = 1'b0;
        end
    endtask

    // called at a clock edge; returns at the edge that accepts the transaction
    task automatic send_sample(input t_value v, input logic eos);
        int gap;
        gap = in_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.sample_value <= v;
        in_if.end_of_set   <= eos;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
        absorb_sample(v, eos);
    endtask

    task automatic send_list(input t_value_list vals);
        int i;
        for (i = 0; i < vals.size(); i++)
            send_sample(vals[i], i == vals.size() - 1);
    endtask

    function automatic t_value pick_value(input t_value_mix mix);
        t_value v;
        case (mix)
            VALUES_WIDE: v = $urandom;
            VALUES_NARROW: v = t_value'(int'($urandom_range(0, 8)) - 4);
            default: begin
                case ($urandom_range(0, 5))
                    0: v = VALUE_MIN;
                    1: v = VALUE_MAX;
                    2: v = '0;
                    3: v = '1;
                    4: v = t_value'(1);
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_set(input int n, input t_value_mix mix);
        int i;
        for (i = 0; i < n; i++)
            send_sample(pick_value(mix), i == n - 1);
    endtask

    task automatic test_directed();
        t_value_list vals;
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        vals = '{VALUE_MAX};
        send_list(vals);
        vals = '{VALUE_MIN};
        send_list(vals);
        vals = '{7, -7};
        send_list(vals);
        vals = '{VALUE_MAX, VALUE_MIN, 0, -1, 1, VALUE_MIN + 1,
                 t_value'(32'h5555_5555), t_value'(32'haaaa_aaaa)};
        send_list(vals);
        // equal values
        vals = '{5, -3, 5, 5, -3};
        send_list(vals);
        vals = '{3, 2, 1, 0, -1, -2};
        send_list(vals);
    endtask

    task automatic test_capacity();
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        send_set(MAX_ITEMS, VALUES_WIDE);
        // marked transaction arrives on a full store and is dropped
        send_set(MAX_ITEMS + 3, VALUES_EDGE);
        // flag must clear for the next set
        send_set(1, VALUES_WIDE);
    endtask

    task automatic test_random();
        int         sent;
        int         n;
        int         pick;
        t_value_mix mix;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                n = $urandom_range(1, 8);
            else if (pick < 95)
                n = $urandom_range(9, MAX_ITEMS);
            else
                n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            case ($urandom_range(0, 2))
                0: mix = VALUES_WIDE;
                1: mix = VALUES_NARROW;
                default: mix = VALUES_EDGE;
            endcase
            in_idle_en  = ($urandom_range(0, 4) != 0);
            out_idle_en = ($urandom_range(0, 4) != 0);
            send_set(n, mix);
            sent += n;
        end
    endtask

    // result side: random stalls, each accepted transaction checked in order
    initial begin
        int            gap;
        t_sorted_entry want;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = out_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            results_checked++;
            if (sorted_expect.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d",
                                          out_if.sorted_value));
            end else begin
                want = sorted_expect.pop_front();
                if (out_if.sorted_value !== want.value)
                    report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                              out_if.sorted_value, want.value));
                if (out_if.final_item !== want.last)
                    report_mismatch($sformatf("final_item %b, expected %b",
                                              out_if.final_item, want.last));
                if (out_if.capacity_exceeded !== want.overflow)
                    report_mismatch($sformatf("capacity_exceeded %b, expected %b",
                                              out_if.capacity_exceeded, want.overflow));
            end
        end
    end

    initial begin
        error_count     = 0;
        sets_sent       = 0;
        items_sent      = 0;
        results_checked = 0;
        overflow_sets   = 0;
        held_count      = 0;
        held_overflow   = 1'b0;
        in_idle_en      = 1'b1;
        out_idle_en     = 1'b1;
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.sample_value <= '0;
        in_if.end_of_set   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_capacity();
        test_random();
        in_if.valid <= 1'b0;

        while (sorted_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d sets in %0d transactions, %0d of them over capacity",
                 sets_sent, items_sent, overflow_sets);
        $display("checked %0d sorted results, %0d mismatches", results_checked, error_count);
        if (error_count == 0)
            $display("integer_merge_sorter_core test passed");
        else
            $display("integer_merge_sorter_core test failed");
        $finish;
    end

endmodule
